// File: src/sprc_pkg.sv
// Shared types, constants and helper functions of the shared page run coalescer.
`default_nettype none

package sprc_pkg;

    // Address and field geometry
    localparam int ADDR_BITS      = 48;
    localparam int PAGE_SHIFT_MIN = 12;
    localparam int IPA_W          = 48;
    localparam int OUT_W          = 48;
    localparam int ATTR_W         = 64;
    localparam int PAGES_W        = 36;
    localparam int COUNT_W        = 32;
    localparam int LEVEL_W        = 2;
    localparam int SHIFT_W        = 6;

    // Configuration port geometry and register indexes
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_LOCK_ENABLE = 1'b0;

    // Request kinds
    localparam logic REQ_ENTRY  = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // Address field of a leaf entry: bits ADDR_BITS-1 down to PAGE_SHIFT_MIN
    localparam logic [63:0] ADDR_MASK =
        ((64'd1 << ADDR_BITS) - 64'd1) & ~((64'd1 << PAGE_SHIFT_MIN) - 64'd1);
    localparam logic [63:0] ADDR_TOP = (64'd1 << ADDR_BITS) - 64'd1;

    // Execute-never and access-permission fields of the lock rewrite
    localparam int XN_SHIFT = 53;
    localparam int AP_SHIFT = 6;
    localparam logic [ATTR_W-1:0] LOCK_CLEAR = (64'h3 << XN_SHIFT) | (64'h3 << AP_SHIFT);
    localparam logic [ATTR_W-1:0] LOCK_SET   = (64'h2 << XN_SHIFT) | (64'h1 << AP_SHIFT);

    localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic              req_type;
        logic [IPA_W-1:0]  entry_ipa;
        logic [LEVEL_W-1:0] entry_level;
        logic [OUT_W-1:0]  entry_out_addr;
        logic [ATTR_W-1:0] entry_attr;
        logic [63:0]       host_entry;
    } req_t;

    typedef struct packed {
        logic               run_valid;
        logic [PAGES_W-1:0] run_pages;
        logic [IPA_W-1:0]   run_ipa;
        logic [OUT_W-1:0]   run_out_addr;
        logic [ATTR_W-1:0]  run_attr;
        logic [63:0]        run_host_entry;
        logic [LEVEL_W-1:0] run_level;
        logic [COUNT_W-1:0] shared_total;
        logic               rewrite_valid;
        logic [ATTR_W-1:0]  rewritten_attr;
    } rsp_t;

    // Page size shift of a table level
    function automatic logic [SHIFT_W-1:0] level_shift(input logic [LEVEL_W-1:0] level);
        logic [SHIFT_W-1:0] sh;
        unique case (level)
            2'd0:    sh = 6'd39;
            2'd1:    sh = 6'd30;
            2'd2:    sh = 6'd21;
            default: sh = 6'd12;
        endcase
        return sh;
    endfunction

    // Largest page count whose span still fits below 2^ADDR_BITS
    function automatic logic [63:0] level_limit(input logic [LEVEL_W-1:0] level);
        logic [63:0] lim;
        unique case (level)
            2'd0:    lim = ADDR_TOP >> 39;
            2'd1:    lim = ADDR_TOP >> 30;
            2'd2:    lim = ADDR_TOP >> 21;
            default: lim = ADDR_TOP >> 12;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

// File: src/sprc_cfg.sv
// Configuration register file: lock mode control.
`default_nettype none

module sprc_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sprc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sprc_pkg::PDATA_W-1:0] pwdata,
    output logic      [sprc_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output logic                             lock_enable
);
    import sprc_pkg::*;

    logic reg_index;
    logic wr_en;
    logic lock_enable_reg;
    logic lock_enable_next;

    assign reg_index = paddr[PADDR_W-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    // Decode a write to the lock register
    always_comb
    begin
        lock_enable_next = lock_enable_reg;
        if (wr_en && (reg_index == REG_LOCK_ENABLE))
        begin
            lock_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_enable_reg <= 1'b0;
        end
        else
        begin
            lock_enable_reg <= lock_enable_next;
        end
    end

    // Return the register value on reads
    always_comb
    begin
        prdata = '0;
        if (psel && (reg_index == REG_LOCK_ENABLE))
        begin
            prdata = {{(PDATA_W-1){1'b0}}, lock_enable_reg};
        end
    end

    assign lock_enable = lock_enable_reg;

endmodule

`default_nettype wire

// File: src/sprc_merge.sv
// Open run state and the merge decision for one request item.
`default_nettype none

module sprc_merge (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           lock_enable,
    input  wire logic           accept,
    input  wire sprc_pkg::req_t req,
    output sprc_pkg::rsp_t      rsp
);
    import sprc_pkg::*;

    logic [PAGES_W-1:0] open_pages_reg,      open_pages_next;
    logic [IPA_W-1:0]   open_ipa_reg,        open_ipa_next;
    logic [OUT_W-1:0]   open_out_addr_reg,   open_out_addr_next;
    logic [ATTR_W-1:0]  open_attr_reg,       open_attr_next;
    logic [63:0]        open_host_entry_reg, open_host_entry_next;
    logic [LEVEL_W-1:0] open_level_reg,      open_level_next;
    logic [COUNT_W-1:0] shared_count_reg,    shared_count_next;

    logic [OUT_W-1:0]   phys;
    logic [ATTR_W-1:0]  attr;
    logic [ATTR_W-1:0]  eff_attr;
    logic               shared;
    logic               run_open;
    logic [SHIFT_W-1:0] sh;
    logic [63:0]        expect_addr;
    logic               continues;

    // Mask the incoming entry down to its address and attribute parts
    assign phys     = req.entry_out_addr & ADDR_MASK[OUT_W-1:0];
    assign attr     = req.entry_attr & ~ADDR_MASK;
    assign shared   = |(req.host_entry & ADDR_MASK);
    assign eff_attr = lock_enable ? ((attr & ~LOCK_CLEAR) | LOCK_SET) : attr;
    assign run_open = (open_pages_reg != '0);

    // Check whether the entry extends the open run
    assign sh          = level_shift(req.entry_level);
    assign expect_addr = 64'(open_out_addr_reg) + (64'(open_pages_reg) << sh);
    assign continues   = (open_attr_reg == eff_attr)
                      && (open_level_reg == req.entry_level)
                      && (open_pages_reg != PAGES_MAX)
                      && (64'(open_pages_reg) <= level_limit(req.entry_level))
                      && (expect_addr == 64'(phys));

    // Next state and result of this item
    always_comb
    begin
        open_pages_next      = open_pages_reg;
        open_ipa_next        = open_ipa_reg;
        open_out_addr_next   = open_out_addr_reg;
        open_attr_next       = open_attr_reg;
        open_host_entry_next = open_host_entry_reg;
        open_level_next      = open_level_reg;
        shared_count_next    = shared_count_reg;
        rsp                  = '0;

        if (req.req_type == REQ_FINISH)
        begin
            // Flush the open run
            if (run_open)
            begin
                rsp.run_valid   = 1'b1;
                open_pages_next = '0;
            end
        end
        else if (phys != '0)
        begin
            if (shared)
            begin
                if (shared_count_reg != COUNT_MAX)
                begin
                    shared_count_next = shared_count_reg + 1'b1;
                end
                if (lock_enable)
                begin
                    rsp.rewrite_valid  = 1'b1;
                    rsp.rewritten_attr = eff_attr;
                end
                if (run_open && continues)
                begin
                    open_pages_next = open_pages_reg + 1'b1;
                end
                else
                begin
                    // Close any open run and start a new one
                    rsp.run_valid        = run_open;
                    open_pages_next      = PAGES_W'(1);
                    open_ipa_next        = req.entry_ipa;
                    open_out_addr_next   = phys;
                    open_attr_next       = eff_attr;
                    open_host_entry_next = req.host_entry;
                    open_level_next      = req.entry_level;
                end
            end
            else if (run_open)
            begin
                // Private page: close the open run
                rsp.run_valid   = 1'b1;
                open_pages_next = '0;
            end
        end

        if (rsp.run_valid)
        begin
            rsp.run_pages      = open_pages_reg;
            rsp.run_ipa        = open_ipa_reg;
            rsp.run_out_addr   = open_out_addr_reg;
            rsp.run_attr       = open_attr_reg;
            rsp.run_host_entry = open_host_entry_reg;
            rsp.run_level      = open_level_reg;
        end
        rsp.shared_total = shared_count_next;
    end

    // Run occupancy and shared count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_pages_reg   <= '0;
            shared_count_reg <= '0;
        end
        else if (accept)
        begin
            open_pages_reg   <= open_pages_next;
            shared_count_reg <= shared_count_next;
        end
    end

    // Run descriptor, only meaningful while a run is open
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            open_ipa_reg        <= open_ipa_next;
            open_out_addr_reg   <= open_out_addr_next;
            open_attr_reg       <= open_attr_next;
            open_host_entry_reg <= open_host_entry_next;
            open_level_reg      <= open_level_next;
        end
    end

endmodule

`default_nettype wire

// File: src/sprc_outbuf.sv
// Two-entry result buffer: result register plus skid register.
`default_nettype none

module sprc_outbuf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire sprc_pkg::rsp_t load_data,
    output logic                load_ready,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output sprc_pkg::rsp_t      rsp
);
    import sprc_pkg::*;

    rsp_t out_reg,  out_next;
    rsp_t skid_reg, skid_next;
    logic out_valid_reg,  out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic take;

    assign take       = out_valid_reg && rsp_ready;
    assign load_ready = !skid_valid_reg;

    // Advance the skid entry, then place the new item
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (load)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = load_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = load_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// File: src/shared_page_run_coalescer.sv
// Top level of the shared page run coalescer.
//
//  Channel  Handshake            Payload        Role
//  req      req_valid/req_ready  req (req_t)    leaf entry or finish item
//  rsp      rsp_valid/rsp_ready  rsp (rsp_t)    one result per request item
//  apb      psel/penable/pready  paddr/pwdata   lock_enable register
//
// One item is accepted per cycle while the skid register is empty; its result is registered before rsp_valid shows it.
// The merge compare and state update sit between the run registers and the result register.
// A skid register holds one extra result, so input stalls only when two results wait.
// Reset closes the open run, clears the shared count and lock mode.
`default_nettype none

module shared_page_run_coalescer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire sprc_pkg::req_t               req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output sprc_pkg::rsp_t                    rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sprc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sprc_pkg::PDATA_W-1:0] pwdata,
    output logic      [sprc_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);
    import sprc_pkg::*;

    logic lock_enable;
    logic accept;
    rsp_t result;

    assign accept = req_valid && req_ready;

    // Configuration registers
    sprc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .lock_enable (lock_enable)
    );

    // Run merge and counting
    sprc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lock_enable (lock_enable),
        .accept      (accept),
        .req         (req),
        .rsp         (result)
    );

    // Result buffering
    sprc_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_data  (result),
        .load_ready (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// File: src/sprc_checker.sv
// Port-level checker for the shared page run coalescer and its bind.
`default_nettype none

module sprc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire sprc_pkg::rsp_t rsp
);
    import sprc_pkg::*;

    // A stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed");

    // A reported run is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.run_valid |-> rsp.run_pages != '0)
        else $error("reported run has no pages");

    // No run reported means all run fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.run_valid |->
            rsp.run_pages == '0 && rsp.run_ipa == '0 && rsp.run_out_addr == '0 &&
            rsp.run_attr == '0 && rsp.run_host_entry == '0 && rsp.run_level == '0)
        else $error("run fields set without a run");

    // Rewritten attributes carry execute-never, read-only and nothing otherwise
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            (rsp.rewrite_valid &&
             ((rsp.rewritten_attr & LOCK_CLEAR) == LOCK_SET)) ||
            (!rsp.rewrite_valid && rsp.rewritten_attr == '0))
        else $error("bad rewritten attributes");

    // Input is taken when no result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled with empty result side");

endmodule

bind shared_page_run_coalescer sprc_checker u_sprc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// File: tb/shared_page_run_coalescer_test.sv
// Self-checking testbench for the shared page run coalescer: directed and random items.
`timescale 1ns / 100ps

module shared_page_run_coalescer_test;
    import sprc_pkg::*;

    // Byte address of the lock register (register index times four)
    localparam logic [PADDR_W-1:0] LOCK_REG_ADDR = {REG_LOCK_ENABLE, 2'b00};

    // Tracks the open run and the shared count, and holds the results still due
    class page_run_board;
        rsp_t               results_due[$];
        int                 mismatches;
        logic               lock_mode;
        logic [PAGES_W-1:0] open_pages;
        logic [IPA_W-1:0]   open_ipa;
        logic [OUT_W-1:0]   open_out;
        logic [ATTR_W-1:0]  open_attr;
        logic [63:0]        open_host;
        logic [LEVEL_W-1:0] open_level;
        logic [COUNT_W-1:0] shared_count;

        function new();
            mismatches   = 0;
            lock_mode    = 1'b0;
            open_pages   = '0;
            open_ipa     = '0;
            open_out     = '0;
            open_attr    = '0;
            open_host    = '0;
            open_level   = '0;
            shared_count = '0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void report_open(inout rsp_t r);
            r.run_valid      = 1'b1;
            r.run_pages      = open_pages;
            r.run_ipa        = open_ipa;
            r.run_out_addr   = open_out;
            r.run_attr       = open_attr;
            r.run_host_entry = open_host;
            r.run_level      = open_level;
        endfunction

        function void begin_run(req_t item, logic [63:0] phys, logic [63:0] attr);
            open_pages = 1;
            open_ipa   = item.entry_ipa;
            open_level = item.entry_level;
            open_out   = phys[OUT_W-1:0];
            open_attr  = attr;
            open_host  = item.host_entry;
        endfunction

        // Work out the result of one accepted item and queue it
        function void note_item(req_t item);
            rsp_t        r;
            logic [63:0] phys;
            logic [63:0] attr;
            int          sh;
            logic        joins;
            r    = '0;
            phys = {16'd0, item.entry_out_addr} & ADDR_MASK;
            attr = item.entry_attr & ~ADDR_MASK;
            if (item.req_type == REQ_FINISH) begin
                if (open_pages != 0) begin
                    report_open(r);
                    open_pages = 0;
                end
            end else if (phys != 0) begin
                if ((item.host_entry & ADDR_MASK) != 0) begin
                    if (shared_count != COUNT_MAX)
                        shared_count++;
                    if (lock_mode) begin
                        attr = (attr & ~LOCK_CLEAR) | LOCK_SET;
                        r.rewrite_valid  = 1'b1;
                        r.rewritten_attr = attr;
                    end
                    // Continue only with equal attributes and level, room left, next address
                    sh    = 39 - 9 * item.entry_level;
                    joins = open_attr == attr && open_level == item.entry_level
                            && open_pages != PAGES_MAX
                            && {28'd0, open_pages} <= (ADDR_TOP >> sh)
                            && ({16'd0, open_out} + ({28'd0, open_pages} << sh)) == phys;
                    if (open_pages == 0) begin
                        begin_run(item, phys, attr);
                    end else if (joins) begin
                        open_pages++;
                    end else begin
                        report_open(r);
                        begin_run(item, phys, attr);
                    end
                end else if (open_pages != 0) begin
                    report_open(r);
                    open_pages = 0;
                end
            end
            r.shared_total = shared_count;
            results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (results_due.size() == 0) begin
                $error("result item with nothing outstanding: %h", got);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            compare_field("run_valid", want.run_valid, got.run_valid);
            compare_field("run_pages", want.run_pages, got.run_pages);
            compare_field("run_ipa", want.run_ipa, got.run_ipa);
            compare_field("run_out_addr", want.run_out_addr, got.run_out_addr);
            compare_field("run_attr", want.run_attr, got.run_attr);
            compare_field("run_host_entry", want.run_host_entry, got.run_host_entry);
            compare_field("run_level", want.run_level, got.run_level);
            compare_field("shared_total", want.shared_total, got.shared_total);
            compare_field("rewrite_valid", want.rewrite_valid, got.rewrite_valid);
            compare_field("rewritten_attr", want.rewritten_attr, got.rewritten_attr);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    page_run_board board;
    int idle_pct;
    int stall_pct;
    int hold_request;
    int hold_left;
    int useful_sent;

    shared_page_run_coalescer uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check result items and drive ready, with an optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp);
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else
            rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #1_000_000;
        $display("shared_page_run_coalescer_test: errors");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] shared_host();
        logic [63:0] h;
        h = rand64();
        if ((h & ADDR_MASK) == 0)
            h[PAGE_SHIFT_MIN] = 1'b1;
        return h;
    endfunction

    function automatic logic [63:0] plain_host();
        return rand64() & ~ADDR_MASK;
    endfunction

    function automatic req_t make_entry(logic [63:0] ipa, int lvl, logic [63:0] out,
                                        logic [63:0] attr, logic [63:0] host);
        req_t r;
        r.req_type       = REQ_ENTRY;
        r.entry_ipa      = ipa[IPA_W-1:0];
        r.entry_level    = lvl[LEVEL_W-1:0];
        r.entry_out_addr = out[OUT_W-1:0];
        r.entry_attr     = attr;
        r.host_entry     = host;
        return r;
    endfunction

    // Finish item; the other fields carry noise and must be ignored
    function automatic req_t finish_item();
        req_t r;
        r          = make_entry(rand64(), $urandom_range(3), rand64(), rand64(), rand64());
        r.req_type = REQ_FINISH;
        return r;
    endfunction

    // Offer one item after an optional idle gap; return once it is accepted
    task automatic send_item(input req_t item);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_item(item);
        if (item.req_type == REQ_FINISH || (item.entry_out_addr & ADDR_MASK) != 0)
            useful_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write the lock register, then read it back
    task automatic program_lock(input logic value);
        logic [PDATA_W-1:0] seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LOCK_REG_ADDR;
        pwdata  <= {{(PDATA_W-1){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.lock_mode = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen[0] !== value)
        begin
            $error("lock_enable readback: expected %h, got %h", value, seen[0]);
            board.mismatches++;
        end
    endtask

    // Mostly a well-formed run of contiguous pages, otherwise a noise item
    task automatic send_burst();
        int          kind;
        int          lvl;
        int          len;
        logic [63:0] page;
        logic [63:0] out;
        logic [63:0] ipa;
        logic [63:0] attr;
        logic [63:0] a;
        kind = $urandom_range(99);
        if (kind < 72)
        begin
            lvl  = $urandom_range(3);
            page = 64'd1 << (39 - 9 * lvl);
            len  = $urandom_range(1, 8);
            out  = rand64() & ADDR_MASK & ~(page - 1);
            if (out == 0)
                out = page;
            ipa  = rand64() & ADDR_TOP & ~(page - 1);
            attr = rand64();
            repeat (len)
            begin
                a = attr;
                // flip ignored address-field bits or the lock-rewritten bits now and then
                if ($urandom_range(3) == 0)
                    a ^= rand64() & (LOCK_CLEAR | ADDR_MASK);
                // skip a page to break the run
                if ($urandom_range(15) == 0)
                    out += page;
                send_item(make_entry(ipa, lvl, out | $urandom_range(4095), a, shared_host()));
                out += page;
                ipa += page;
            end
            case ($urandom_range(3))
                0: send_item(finish_item());
                1: send_item(make_entry(rand64(), $urandom_range(3), rand64(), rand64(),
                                        plain_host()));
                default: ;
            endcase
        end
        else
        begin
            case ($urandom_range(3))
                0: send_item(make_entry(rand64(), $urandom_range(3), rand64(), rand64(),
                                        rand64()));
                1: send_item(make_entry(rand64(), $urandom_range(3), $urandom_range(4095),
                                        rand64(), shared_host()));
                2: send_item(make_entry(rand64(), $urandom_range(3), rand64(), rand64(),
                                        plain_host()));
                default: send_item(finish_item());
            endcase
        end
    endtask

    initial
    begin
        board        = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        hold_left    = 0;
        useful_sent  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items, lock off
        send_item(finish_item());
        send_item(make_entry(64'h1000, 3, 64'h0, 64'h0, shared_host()));
        send_item(make_entry(64'h2000, 3, 64'hFFF, 64'h0, shared_host()));
        send_item(make_entry(64'h3000, 3, 64'h5000, 64'h0, plain_host()));
        send_item(make_entry(64'hFFFF_FFFF_D000, 3, 64'h1000, '1, '1));
        send_item(make_entry(64'hFFFF_FFFF_E000, 3, 64'h2000, '1, '1));
        send_item(make_entry(64'hFFFF_FFFF_F000, 3, 64'h3000, '1, shared_host()));
        send_item(make_entry(64'h0, 2, 64'h0020_0000, '1, shared_host()));
        send_item(make_entry(64'h0020_0000, 2, 64'h0040_0000, 64'h0, shared_host()));
        send_item(make_entry(64'h0040_0000, 2, 64'h0080_0000, 64'h0, shared_host()));
        send_item(make_entry(64'h0060_0000, 2, 64'h00A0_0000, 64'h0, plain_host()));
        send_item(make_entry(64'h0, 0, 64'hFF00_0000_0000, 64'h0, shared_host()));
        send_item(make_entry(64'h80_0000_0000, 0, 64'hFF80_0000_0000, 64'h0, shared_host()));
        send_item(make_entry(64'h100_0000_0000, 0, 64'h0080_0000_0000, 64'h0, shared_host()));
        send_item(make_entry('1, 1, 64'hFFFF_FFFF_FFFF, rand64(), shared_host()));
        send_item(finish_item());
        send_item(finish_item());
        drain_results();

        // Directed items, lock on
        program_lock(1'b1);
        send_item(make_entry(64'h5000, 3, 64'h5000, 64'h0, shared_host()));
        send_item(make_entry(64'h6000, 3, 64'h6000, LOCK_CLEAR, shared_host()));
        send_item(make_entry(64'h7000, 3, 64'h7000, LOCK_CLEAR, plain_host()));
        send_item(make_entry(64'h8000, 3, 64'h0, '1, shared_host()));
        send_item(make_entry(64'h9000, 3, 64'h9000, 64'h0, shared_host()));
        send_item(finish_item());
        drain_results();

        // Random phases: no idling with a long receiver hold-off, then idling mixes
        useful_sent = 0;
        program_lock(1'b1);
        hold_request = 80;
        while (useful_sent < 190)
            send_burst();
        drain_results();

        program_lock(1'b0);
        idle_pct = 65;
        while (useful_sent < 380)
            send_burst();
        drain_results();

        program_lock(1'b1);
        idle_pct  = 0;
        stall_pct = 65;
        while (useful_sent < 570)
            send_burst();
        drain_results();

        program_lock(1'b0);
        idle_pct  = 13;
        stall_pct = 13;
        while (useful_sent < 760)
            send_burst();
        send_item(finish_item());
        drain_results();

        if (board.mismatches == 0)
            $display("shared_page_run_coalescer_test: clean");
        else
            $display("shared_page_run_coalescer_test: errors");
        $finish;
    end
endmodule
